FILE: rtl/layered_fader_pickup_macros.svh
// Assertion macros for the fader pickup RTL.
`ifndef LAYERED_FADER_PICKUP_MACROS_SVH
`define LAYERED_FADER_PICKUP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define LFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fader pickup: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define LFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fader pickup: next-cycle check failed");
`else
`define LFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/lfp_pkg.sv
// Types and constants of the layered fader pickup.
`default_nettype none
package lfp_pkg;
	localparam int NUM_CH      = 7;
	localparam int NUM_LAYERS  = 3;
	localparam int NUM_BUTTONS = 3;
	localparam int CH_W        = 3;
	localparam int LAYER_W     = 2;
	localparam int THR_W       = 10;

	typedef logic [CH_W-1:0]    ch_t;
	typedef logic [LAYER_W-1:0] layer_t;
	typedef logic [THR_W-1:0]   thr_t;

	localparam thr_t THR_RESET = thr_t'(30);
	localparam ch_t  LAST_CH   = ch_t'(NUM_CH - 1);

	// Control of the channel step in progress.
	typedef struct packed {
		logic   vld;
		ch_t    ch;
		layer_t layer;
		logic   capture;
		logic   last;
	} step_t;
endpackage
`default_nettype wire

FILE: rtl/lfp_frame_if.sv
// Scan frame channel: layer buttons and fader samples.
`default_nettype none
interface lfp_frame_if import lfp_pkg::*; #(parameter int SAMPLE_BITS = 10);
	logic                         valid;
	logic                         ready;
	logic [NUM_BUTTONS-1:0]       layer_buttons;
	logic [SAMPLE_BITS-1:0]       fader_0;
	logic [SAMPLE_BITS-1:0]       fader_1;
	logic [SAMPLE_BITS-1:0]       fader_2;
	logic [SAMPLE_BITS-1:0]       fader_3;
	logic [SAMPLE_BITS-1:0]       fader_4;
	logic [SAMPLE_BITS-1:0]       fader_5;
	logic [SAMPLE_BITS-1:0]       fader_6;

	modport source (output valid, layer_buttons, fader_0, fader_1, fader_2, fader_3,
		fader_4, fader_5, fader_6, input ready);
	modport sink (input valid, layer_buttons, fader_0, fader_1, fader_2, fader_3,
		fader_4, fader_5, fader_6, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfp_result_if.sv
// Per-channel result channel.
`default_nettype none
interface lfp_result_if import lfp_pkg::*; #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	ch_t                    channel;
	layer_t                 layer;
	logic [SAMPLE_BITS-1:0] level;
	logic [SAMPLE_BITS-1:0] peak;
	logic                   locked;
	logic                   last;

	modport source (output valid, channel, layer, level, peak, locked, last, input ready);
	modport sink (input valid, channel, layer, level, peak, locked, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfp_frame_in.sv
// Frame input register, layer selection and channel sequencer.
`default_nettype none
module lfp_frame_in import lfp_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lfp_frame_if.sink                   frame,
	input  wire logic                   advance,
	output step_t                       step,
	output logic [SAMPLE_BITS-1:0]      sample
);
	logic                   busy_s1;
	ch_t                    ch_s1;
	layer_t                 layer_s1;
	logic                   capture_s1;
	logic [SAMPLE_BITS-1:0] faders_s1 [NUM_CH];
	layer_t                 active_layer_q;
	logic                   capture_pending_q;

	layer_t                 next_layer;
	logic                   next_capture;
	logic                   accept;

	// A new frame enters as the last channel of the current one moves on.
	assign frame.ready = !busy_s1 || (advance && ch_s1 == LAST_CH);
	assign accept      = frame.valid && frame.ready;

	// The highest-numbered pressed button wins; none pressed keeps the layer.
	always_comb begin
		next_layer = active_layer_q;
		for (int b = 0; b < NUM_LAYERS; b++) begin
			if (!frame.layer_buttons[b]) begin
				next_layer = layer_t'(b);
			end
		end
		next_capture = (next_layer != active_layer_q) || capture_pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1           <= 1'b0;
			ch_s1             <= '0;
			active_layer_q    <= '0;
			capture_pending_q <= 1'b1;
		end else if (accept) begin
			busy_s1           <= 1'b1;
			ch_s1             <= '0;
			active_layer_q    <= next_layer;
			capture_pending_q <= 1'b0;
		end else if (advance && busy_s1) begin
			if (ch_s1 == LAST_CH) begin
				busy_s1 <= 1'b0;
			end else begin
				ch_s1 <= ch_s1 + ch_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			layer_s1     <= next_layer;
			capture_s1   <= next_capture;
			faders_s1[0] <= frame.fader_0;
			faders_s1[1] <= frame.fader_1;
			faders_s1[2] <= frame.fader_2;
			faders_s1[3] <= frame.fader_3;
			faders_s1[4] <= frame.fader_4;
			faders_s1[5] <= frame.fader_5;
			faders_s1[6] <= frame.fader_6;
		end
	end

	always_comb begin
		step.vld     = busy_s1;
		step.ch      = ch_s1;
		step.layer   = layer_s1;
		step.capture = capture_s1;
		step.last    = (ch_s1 == LAST_CH);
	end

	assign sample = faders_s1[ch_s1];
endmodule
`default_nettype wire

FILE: rtl/lfp_chan_proc.sv
// Per-channel pickup state, level and peak stores, and the result register.
`default_nettype none
`include "layered_fader_pickup_macros.svh"
module lfp_chan_proc import lfp_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire step_t                  step,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   cfg_we,
	input  wire thr_t                   cfg_wdata,
	output logic                        advance,
	lfp_result_if.source                result
);
	thr_t                   thr_q;
	logic [SAMPLE_BITS-1:0] levels_q [NUM_LAYERS][NUM_CH];
	logic [SAMPLE_BITS-1:0] peaks_q  [NUM_LAYERS][NUM_CH];
	logic [SAMPLE_BITS-1:0] start_q  [NUM_CH];
	logic [NUM_CH-1:0]      lock_q;

	logic                   res_valid_q;
	ch_t                    res_ch_q;
	layer_t                 res_layer_q;
	logic [SAMPLE_BITS-1:0] res_level_q;
	logic [SAMPLE_BITS-1:0] res_peak_q;
	logic                   res_locked_q;
	logic                   res_last_q;

	logic                   fire;
	logic [SAMPLE_BITS-1:0] thr_eff;
	logic [SAMPLE_BITS-1:0] start_eff;
	logic [SAMPLE_BITS-1:0] travel;
	logic                   lock_new;
	logic [SAMPLE_BITS-1:0] lvl_old;
	logic [SAMPLE_BITS-1:0] lvl_new;
	logic [SAMPLE_BITS-1:0] pk_old;
	logic [SAMPLE_BITS-1:0] pk_new;

	assign advance = !res_valid_q || result.ready;
	assign fire    = advance && step.vld;
	assign thr_eff = SAMPLE_BITS'(thr_q);

	// A capture frame takes its start from the sample itself, so it stays locked.
	always_comb begin
		start_eff = step.capture ? sample : start_q[step.ch];
		travel    = (sample >= start_eff) ? sample - start_eff : start_eff - sample;
		lock_new  = (step.capture || lock_q[step.ch]) && !(travel > thr_eff);
		lvl_old   = levels_q[step.layer][step.ch];
		pk_old    = peaks_q[step.layer][step.ch];
		lvl_new   = lock_new ? lvl_old : sample;
		pk_new    = (lvl_new > pk_old) ? lvl_new : pk_old;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= '1;
			for (int l = 0; l < NUM_LAYERS; l++) begin
				for (int c = 0; c < NUM_CH; c++) begin
					levels_q[l][c] <= '0;
					peaks_q[l][c]  <= '0;
				end
			end
		end else if (fire) begin
			lock_q[step.ch]              <= lock_new;
			levels_q[step.layer][step.ch] <= lvl_new;
			peaks_q[step.layer][step.ch]  <= pk_new;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step.capture) begin
			start_q[step.ch] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_ch_q     <= step.ch;
			res_layer_q  <= step.layer;
			res_level_q  <= lvl_new;
			res_peak_q   <= pk_new;
			res_locked_q <= lock_new;
			res_last_q   <= step.last;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.channel = res_ch_q;
	assign result.layer   = res_layer_q;
	assign result.level   = res_level_q;
	assign result.peak    = res_peak_q;
	assign result.locked  = res_locked_q;
	assign result.last    = res_last_q;

	`LFP_ASSERT_NXT(a_capture_locks, clk, arst_n, fire && step.capture, res_locked_q)
	`LFP_ASSERT_IMP(a_peak_covers_level, clk, arst_n, res_valid_q, res_peak_q >= res_level_q)
	`LFP_ASSERT_IMP(a_last_on_final_ch, clk, arst_n, res_valid_q, res_last_q == (res_ch_q == LAST_CH))
	`LFP_ASSERT_NXT(a_unlocked_tracks, clk, arst_n, fire && !lock_new, res_level_q == $past(sample))
endmodule
`default_nettype wire

FILE: rtl/layered_fader_pickup.sv
// Layered fader pickup with soft takeover: frame in, seven channel results out.
//
// The frame channel carries three active-low layer buttons and seven fader
// samples; the result channel carries one result per fader channel, channel 0
// first, with last set on channel 6. Both are valid/ready; a transfer happens
// on a rising edge with valid and ready high. The threshold register must be
// written through cfg_we/cfg_wdata only while no frame is in flight; the
// block itself does not enforce it. A transferred frame is held in the frame
// input register and its channels are loaded into the result register,
// channel 0 first, by the single channel unit that steps through the channels
// one per cycle while the receiver takes results. The next frame is taken at
// the edge that loads channel 6, so frames run back to back.
// Reset selects layer 0, clears all stored levels and peaks, locks every
// channel and makes the first frame capture start positions; the threshold
// returns to 30. When the receiver holds ready low, the result register holds,
// the channel sequencer stops and the frame channel deasserts ready.
`default_nettype none
module layered_fader_pickup import lfp_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lfp_frame_if.sink    frame,
	lfp_result_if.source result,
	input  wire logic    cfg_we,
	input  wire thr_t    cfg_wdata
);
	step_t                  step;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   advance;

	lfp_frame_in #(.SAMPLE_BITS(SAMPLE_BITS)) u_frame_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame),
		.advance (advance),
		.step    (step),
		.sample  (sample)
	);

	lfp_chan_proc #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_proc (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.result    (result)
	);
endmodule
`default_nettype wire

FILE: dv/layered_fader_pickup_tb.sv
// Self-checking testbench for the layered fader pickup: directed and random frames against a behavioural predictor.
`timescale 1ns / 100ps

module layered_fader_pickup_tb;
	import lfp_pkg::*;

	localparam int SAMPLE_BITS    = 10;
	localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 2;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRESSURE_AT    = 100;
	localparam int PRESSURE_SPAN  = 150;
	localparam int MAX_REPORTS    = 100;

	// Button patterns, active low.
	localparam logic [NUM_BUTTONS-1:0] NO_BUTTON   = 3'b111;
	localparam logic [NUM_BUTTONS-1:0] ALL_BUTTONS = 3'b000;
	localparam logic [NUM_BUTTONS-1:0] PRESS_0     = 3'b110;
	localparam logic [NUM_BUTTONS-1:0] PRESS_1     = 3'b101;
	localparam logic [NUM_BUTTONS-1:0] PRESS_2     = 3'b011;
	localparam logic [NUM_BUTTONS-1:0] PRESS_1_2   = 3'b001;
	localparam logic [NUM_BUTTONS-1:0] PRESS_0_2   = 3'b010;
	localparam logic [NUM_BUTTONS-1:0] PRESS_0_1   = 3'b100;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0]           buttons;
		logic [NUM_CH-1:0][SAMPLE_BITS-1:0] samples;
	} frame_t;

	typedef struct packed {
		ch_t     channel;
		layer_t  layer;
		sample_t level;
		sample_t peak;
		logic    locked;
		logic    last;
	} channel_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	thr_t cfg_wdata;

	lfp_frame_if  #(.SAMPLE_BITS(SAMPLE_BITS)) frame_ch ();
	lfp_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

	layered_fader_pickup #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state, mirroring the block.
	thr_t    threshold_now;
	layer_t  layer_now;
	sample_t stored_level [NUM_LAYERS][NUM_CH];
	sample_t held_peak [NUM_LAYERS][NUM_CH];
	sample_t start_pos [NUM_CH];
	logic    locked_now [NUM_CH];
	logic    capture_due;

	frame_t          frames_to_send [$];
	channel_result_t channel_results_due [$];

	frame_t frame_on_bus;
	int     send_gap;
	int     recv_stall;
	int     results_taken;
	bit     pressure_done;
	bit     busy_idling;
	int     errors;
	int     quiet_cycles;
	int     walk_pos [NUM_CH];

	always #CLK_HALF clk = ~clk;

	function automatic int pick_gap(bit busy);
		int unsigned roll;
		if (!busy)
			return 0;
		roll = $urandom_range(99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Layer selection, start capture and soft takeover for one frame.
	function automatic void takeover_step(frame_t f);
		layer_t          prev_layer;
		int              s;
		int              st;
		int              travel;
		channel_result_t r;
		prev_layer = layer_now;
		for (int b = 0; b < NUM_BUTTONS; b++)
			if (!f.buttons[b])
				layer_now = layer_t'(b);
		if (layer_now != prev_layer || capture_due) begin
			for (int c = 0; c < NUM_CH; c++) begin
				locked_now[c] = 1'b1;
				start_pos[c] = f.samples[c];
			end
			capture_due = 1'b0;
		end
		for (int c = 0; c < NUM_CH; c++) begin
			s = int'(f.samples[c]);
			st = int'(start_pos[c]);
			travel = (s >= st) ? s - st : st - s;
			if (locked_now[c] && travel > int'(threshold_now))
				locked_now[c] = 1'b0;
			if (!locked_now[c])
				stored_level[layer_now][c] = sample_t'(s);
			if (stored_level[layer_now][c] > held_peak[layer_now][c])
				held_peak[layer_now][c] = stored_level[layer_now][c];
			r.channel = ch_t'(c);
			r.layer   = layer_now;
			r.level   = stored_level[layer_now][c];
			r.peak    = held_peak[layer_now][c];
			r.locked  = locked_now[c];
			r.last    = (c == NUM_CH - 1);
			channel_results_due.push_back(r);
		end
	endfunction

	function automatic frame_t make_frame(logic [NUM_BUTTONS-1:0] btn, int base, int step);
		frame_t f;
		f.buttons = btn;
		for (int c = 0; c < NUM_CH; c++)
			f.samples[c] = sample_t'((base + c * step) & SAMPLE_MAX);
		return f;
	endfunction

	// Faders mostly wander around their last position so that channels take over;
	// now and then one jumps anywhere or to an end stop.
	task automatic queue_random_frames(int count);
		frame_t      f;
		int unsigned roll;
		for (int n = 0; n < count; n++) begin
			f.buttons = ($urandom_range(99) < 75) ? NO_BUTTON
				: NUM_BUTTONS'($urandom_range(7));
			for (int c = 0; c < NUM_CH; c++) begin
				roll = $urandom_range(99);
				if (roll < 8)
					walk_pos[c] = $urandom_range(SAMPLE_MAX);
				else if (roll < 10)
					walk_pos[c] = 0;
				else if (roll < 12)
					walk_pos[c] = SAMPLE_MAX;
				else
					walk_pos[c] = walk_pos[c] + int'($urandom_range(128)) - 64;
				if (walk_pos[c] < 0)
					walk_pos[c] = 0;
				if (walk_pos[c] > SAMPLE_MAX)
					walk_pos[c] = SAMPLE_MAX;
				f.samples[c] = sample_t'(walk_pos[c]);
			end
			frames_to_send.push_back(f);
		end
	endtask

	task automatic write_threshold(thr_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold_now = value;
		@(negedge clk);
	endtask

	// Sampled on the falling edge so that queue updates at the rising edge have settled.
	task automatic wait_until_idle();
		while (frames_to_send.size() != 0 || frame_ch.valid || channel_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(string field, sample_t want, sample_t got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
		end
	endtask

	// Frame sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (frame_ch.valid && frame_ch.ready)
				takeover_step(frame_on_bus);
			if (!frame_ch.valid || frame_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					frame_ch.valid <= 1'b0;
				end else if (frames_to_send.size() != 0) begin
					frame_on_bus = frames_to_send.pop_front();
					frame_ch.layer_buttons <= frame_on_bus.buttons;
					frame_ch.fader_0 <= frame_on_bus.samples[0];
					frame_ch.fader_1 <= frame_on_bus.samples[1];
					frame_ch.fader_2 <= frame_on_bus.samples[2];
					frame_ch.fader_3 <= frame_on_bus.samples[3];
					frame_ch.fader_4 <= frame_on_bus.samples[4];
					frame_ch.fader_5 <= frame_on_bus.samples[5];
					frame_ch.fader_6 <= frame_on_bus.samples[6];
					frame_ch.valid <= 1'b1;
					send_gap = pick_gap(busy_idling);
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver and checker.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		channel_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_taken++;
				if (channel_results_due.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, channel %0d", $realtime,
						result_ch.channel);
				end else begin
					want = channel_results_due.pop_front();
					check_field("channel", sample_t'(want.channel), sample_t'(result_ch.channel));
					check_field("layer", sample_t'(want.layer), sample_t'(result_ch.layer));
					check_field("level", want.level, result_ch.level);
					check_field("peak", want.peak, result_ch.peak);
					check_field("locked", sample_t'(want.locked), sample_t'(result_ch.locked));
					check_field("last", sample_t'(want.last), sample_t'(result_ch.last));
				end
			end
			// One long hold-off so that the block backs up and stalls its frame input.
			if (results_taken >= PRESSURE_AT && !pressure_done) begin
				pressure_done = 1'b1;
				recv_stall = PRESSURE_SPAN;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(99) < 30)
					recv_stall = pick_gap(busy_idling);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = THR_RESET;
		frame_ch.valid = 1'b0;
		frame_ch.layer_buttons = NO_BUTTON;
		frame_ch.fader_0 = '0;
		frame_ch.fader_1 = '0;
		frame_ch.fader_2 = '0;
		frame_ch.fader_3 = '0;
		frame_ch.fader_4 = '0;
		frame_ch.fader_5 = '0;
		frame_ch.fader_6 = '0;
		result_ch.ready = 1'b0;
		threshold_now = THR_RESET;
		layer_now = '0;
		capture_due = 1'b1;
		for (int c = 0; c < NUM_CH; c++) begin
			start_pos[c] = '0;
			locked_now[c] = 1'b1;
			walk_pos[c] = SAMPLE_MAX / 2;
			for (int l = 0; l < NUM_LAYERS; l++) begin
				stored_level[l][c] = '0;
				held_peak[l][c] = '0;
			end
		end
		results_taken = 0;
		pressure_done = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		busy_idling = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Threshold at its reset value: capture on the first frame, the edge of the
		// threshold, end stops, peak hold and every button combination.
		frames_to_send.push_back(make_frame(NO_BUTTON, 0, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, 30, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, 31, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, SAMPLE_MAX, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, 0, 0));
		frames_to_send.push_back(make_frame(PRESS_0, 'h2AA, 0));
		frames_to_send.push_back(make_frame(PRESS_1, SAMPLE_MAX, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, SAMPLE_MAX, -10));
		frames_to_send.push_back(make_frame(ALL_BUTTONS, 'h155, 0));
		frames_to_send.push_back(make_frame(PRESS_2, 'h2AA, 0));
		frames_to_send.push_back(make_frame(PRESS_1_2, 'h155, 0));
		frames_to_send.push_back(make_frame(PRESS_0_2, 0, 1));
		frames_to_send.push_back(make_frame(PRESS_0_1, 512, 0));
		frames_to_send.push_back(make_frame(PRESS_0, 700, 50));
		frames_to_send.push_back(make_frame(NO_BUTTON, SAMPLE_MAX, 0));
		queue_random_frames(30);
		wait_until_idle();

		// Zero threshold: any movement takes over, standing still does not.
		busy_idling = 1'b0;
		write_threshold(thr_t'(0));
		frames_to_send.push_back(make_frame(PRESS_1, 100, 0));
		frames_to_send.push_back(make_frame(PRESS_1, 100, 0));
		frames_to_send.push_back(make_frame(PRESS_1, 101, 0));
		queue_random_frames(30);
		wait_until_idle();

		// Full-scale threshold: even an end-to-end move never takes over.
		busy_idling = 1'b1;
		write_threshold(thr_t'(SAMPLE_MAX));
		frames_to_send.push_back(make_frame(PRESS_2, 0, 0));
		frames_to_send.push_back(make_frame(PRESS_0, 0, 0));
		frames_to_send.push_back(make_frame(NO_BUTTON, SAMPLE_MAX, 0));
		queue_random_frames(25);
		wait_until_idle();

		write_threshold(thr_t'($urandom_range(1, 200)));
		queue_random_frames(40);
		wait_until_idle();

		busy_idling = 1'b0;
		write_threshold(THR_RESET);
		queue_random_frames(40);
		wait_until_idle();

		busy_idling = 1'b1;
		write_threshold(thr_t'($urandom_range(SAMPLE_MAX)));
		queue_random_frames(35);
		wait_until_idle();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
